### design/qrd_pkg.sv
// Package for the quadrature rotary decoder: step modes, register indexes,
// decoder state type and the quarter-step transition table. No dependencies.
`timescale 1ns / 1ps

package qrd_pkg;

  localparam int unsigned ModeWidth  = 2;
  localparam int unsigned CodeWidth  = 2;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 2;

  // Step modes.
  localparam logic [ModeWidth-1:0] MODE_FULL    = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_HALF    = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_QUARTER = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] REG_STEP_MODE = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_INVERT_A  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_INVERT_B  = 2'd2;

  // Pin codes, A in the upper bit.
  localparam logic [CodeWidth-1:0] CODE_LL = 2'd0;
  localparam logic [CodeWidth-1:0] CODE_LH = 2'd1;
  localparam logic [CodeWidth-1:0] CODE_HL = 2'd2;
  localparam logic [CodeWidth-1:0] CODE_HH = 2'd3;

  typedef struct packed {
    logic [CodeWidth-1:0] prior_code;
    logic                 turn_dir;
    logic                 primed;
  } qrd_state_t;

  typedef struct packed {
    logic hit;
    logic dir;
  } qrd_quarter_t;

  // Gray-code transition table: a legal single-bit change gives its direction.
  function automatic qrd_quarter_t quarter_lookup(input logic [CodeWidth-1:0] from,
                                                  input logic [CodeWidth-1:0] to);
    qrd_quarter_t res;
    res = '{hit: 1'b1, dir: 1'b0};
    case ({from, to})
      {CODE_HH, CODE_LH}, {CODE_LH, CODE_LL},
      {CODE_LL, CODE_HL}, {CODE_HL, CODE_HH}: res.dir = 1'b0;
      {CODE_LH, CODE_HH}, {CODE_LL, CODE_LH},
      {CODE_HL, CODE_LL}, {CODE_HH, CODE_HL}: res.dir = 1'b1;
      default: res.hit = 1'b0;
    endcase
    return res;
  endfunction

endpackage

### design/qrd_if.sv
// Handshake channels of the quadrature rotary decoder: pin samples in,
// step results out. Depends on nothing.
`timescale 1ns / 1ps

interface qrd_pin_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;

  modport source (output valid, output pin_a, output pin_b, input ready);
  modport sink   (input valid, input pin_a, input pin_b, output ready);
endinterface

interface qrd_step_if;
  logic valid;
  logic ready;
  logic step_direction;

  modport source (output valid, output step_direction, input ready);
  modport sink   (input valid, input step_direction, output ready);
endinterface

### design/quadrature_rotary_decoder_core.sv
// Top level of the quadrature rotary decoder: input register, decode stage,
// result register and configuration registers. Depends on qrd_pkg, qrd_if, qrd_decode.
//
//   Channel   Dir   Payload          Accepted when
//   pin_i     in    pin_a, pin_b     pin_i.valid & pin_i.ready
//   step_o    out   step_direction   step_o.valid & step_o.ready
//   cfg       in    index, data      cfg_we_i
//
// A sample is registered on accept and decoded from the input register; a step result
// is loaded into the result register when the decoded sample leaves the input register.
// One sample per cycle is sustained unless step_o stalls; a sample that gives no
// step frees its slot. A stalled result holds the result register, which then holds
// the input register. Reset clears the mode, the inversion bits and the decoder state.
`timescale 1ns / 1ps

module quadrature_rotary_decoder_core import qrd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  qrd_pin_if.sink                 pin_i,
  qrd_step_if.source              step_o
);

  logic [ModeWidth-1:0] mode_q;
  logic                 invert_a_q;
  logic                 invert_b_q;
  qrd_state_t           state_q, state_d, dec_state;

  logic in_valid_q, in_valid_d;
  logic pin_a_q, pin_b_q;
  logic out_valid_q, out_valid_d;
  logic out_dir_q, out_dir_d;

  logic accept, advance, fire, emit, dir, mode_write;

  assign advance    = !out_valid_q || step_o.ready;
  assign fire       = in_valid_q && advance;
  assign pin_i.ready = !in_valid_q || advance;
  assign accept     = pin_i.valid && pin_i.ready;
  assign mode_write = cfg_we_i && (cfg_index_i == REG_STEP_MODE);

  assign step_o.valid          = out_valid_q;
  assign step_o.step_direction = out_dir_q;

  qrd_decode u_decode (
    .mode_i     (mode_q),
    .invert_a_i (invert_a_q),
    .invert_b_i (invert_b_q),
    .pin_a_i    (pin_a_q),
    .pin_b_i    (pin_b_q),
    .state_i    (state_q),
    .state_o    (dec_state),
    .emit_o     (emit),
    .dir_o      (dir)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_dir_d   = out_dir_q;
    if (advance) begin
      out_valid_d = fire && emit;
      out_dir_d   = dir;
    end

    state_d = state_q;
    if (fire) begin
      state_d = dec_state;
    end
    // A mode write restarts the decoder but keeps the latched direction.
    if (mode_write) begin
      state_d.prior_code = CODE_LL;
      state_d.primed     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FULL;
      invert_a_q  <= 1'b0;
      invert_b_q  <= 1'b0;
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STEP_MODE: mode_q     <= cfg_wdata_i[ModeWidth-1:0];
          REG_INVERT_A:  invert_a_q <= cfg_wdata_i[0];
          REG_INVERT_B:  invert_b_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pin_a_q <= pin_i.pin_a;
      pin_b_q <= pin_i.pin_b;
    end
    out_dir_q <= out_dir_d;
  end

  // A new result is only ever loaded by a decoded sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire))
    else $error("step result appeared without a decoded sample");

  // A mode write always drops the priming.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_write |=> !state_q.primed && state_q.prior_code == CODE_LL)
    else $error("mode write did not restart the decoder");

  // In half and quarter modes a decoded sample leaves the decoder primed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !mode_write && (mode_q == MODE_HALF || mode_q == MODE_QUARTER)
    |=> state_q.primed)
    else $error("decoder not primed after a sample");

  // A quarter step only comes from a change of code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit && !mode_write && mode_q == MODE_QUARTER
    |=> state_q.prior_code != $past(state_q.prior_code))
    else $error("quarter step without a code change");

  // In full mode (and the spare mode 3) a step is emitted only while armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit && mode_q != MODE_HALF && mode_q != MODE_QUARTER
    |-> state_q.prior_code != CODE_LL)
    else $error("full-period step while not armed");

endmodule

### design/qrd_decode.sv
// Combinational step decoder: next state and step result for one pin sample.
// Depends on qrd_pkg.
`timescale 1ns / 1ps

module qrd_decode import qrd_pkg::*; (
  input  logic [ModeWidth-1:0] mode_i,
  input  logic                 invert_a_i,
  input  logic                 invert_b_i,
  input  logic                 pin_a_i,
  input  logic                 pin_b_i,
  input  qrd_state_t           state_i,
  output qrd_state_t           state_o,
  output logic                 emit_o,
  output logic                 dir_o
);

  logic [CodeWidth-1:0] code;
  qrd_quarter_t         quarter;

  assign code    = {pin_a_i ^ invert_a_i, pin_b_i ^ invert_b_i};
  assign quarter = quarter_lookup(state_i.prior_code, code);

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    if ((mode_i == MODE_HALF || mode_i == MODE_QUARTER) && !state_i.primed) begin
      // The first sample only sets the reference code.
      state_o.prior_code = code;
      state_o.primed     = 1'b1;
    end else begin
      case (mode_i)
        MODE_HALF: begin
          if (code == CODE_LL || code == CODE_HH) begin
            if (code != state_i.prior_code) begin
              state_o.prior_code = code;
              emit_o             = 1'b1;
            end
          end else begin
            state_o.turn_dir = state_i.prior_code[0] ^ code[0];
          end
        end
        MODE_QUARTER: begin
          state_o.prior_code = code;
          if (quarter.hit) begin
            state_o.turn_dir = quarter.dir;
            emit_o           = 1'b1;
          end
        end
        default: begin
          // Full period: prior_code serves as the armed flag.
          if (code == CODE_LL) begin
            if (state_i.prior_code != CODE_LL) begin
              state_o.prior_code = CODE_LL;
              emit_o             = 1'b1;
            end
          end else if (code == CODE_HH) begin
            state_o.prior_code = CODE_LH;
          end else if (state_i.prior_code != CODE_LL) begin
            state_o.turn_dir = code[1];
          end
        end
      endcase
    end
  end

  // A step always reports the direction held after this sample.
  assign dir_o = state_o.turn_dir;

endmodule

### tb/tb_quadrature_rotary_decoder_core.sv
// Self-checking testbench for quadrature_rotary_decoder_core: a directed table, then random
// encoder walks with noise. Checks use typed rows or a built-in decoder model.
// Depends on qrd_pkg, qrd_if and the core.
`timescale 1ns / 1ps

module tb_quadrature_rotary_decoder_core;
  import qrd_pkg::*;

  localparam logic [CfgIdxWidth-1:0] REG_UNUSED = 2'd3;
  localparam logic [ModeWidth-1:0]   MODE_SPARE = 2'd3;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 47;
  localparam int DRAIN_CYCLES = 6;
  localparam int NUM_ROWS     = 31;

  typedef enum logic {ROW_PIN, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CfgIdxWidth-1:0]  idx;
    logic [CfgDataWidth-1:0] data;
    logic                    a;
    logic                    b;
    logic                    typed;
    logic                    t_emit;
    logic                    t_dir;
  } stim_row_t;

  // Pin rows with typed set carry their expected step; the others use the decoder model.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
    '{ROW_CFG, REG_STEP_MODE, MODE_HALF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_CFG, REG_STEP_MODE, MODE_QUARTER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_INVERT_A, 2'b11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_STEP_MODE, MODE_QUARTER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_CFG, REG_INVERT_A, 2'b10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_INVERT_B, 2'b01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_UNUSED, 2'b11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_STEP_MODE, MODE_SPARE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIN, REG_STEP_MODE, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic [ModeWidth-1:0] seg_modes [SEGMENTS] = '{MODE_FULL, MODE_HALF, MODE_QUARTER, MODE_SPARE,
                                                 MODE_QUARTER, MODE_HALF, MODE_FULL, MODE_QUARTER};
  int sender_pct_by_phase [4] = '{0, 48, 0, 34};
  int stall_pct_by_phase  [4] = '{0, 0, 48, 34};

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;

  qrd_pin_if  pin_ch ();
  qrd_step_if step_ch ();

  quadrature_rotary_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pin_i       (pin_ch),
    .step_o      (step_ch)
  );

  always #2 clk_i = ~clk_i;

  // Decoder model state and its copy of the registers.
  logic [ModeWidth-1:0] mode_q = MODE_FULL;
  logic                 inv_a_q = 1'b0;
  logic                 inv_b_q = 1'b0;
  logic [CodeWidth-1:0] last_code = CODE_LL;
  logic                 turn_dir_q = 1'b0;
  logic                 primed_q = 1'b0;

  bit pending_steps [$];
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int samples_sent    = 0;
  int steps_seen      = 0;
  int mismatches      = 0;

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Position of a code along the forward Gray walk 0, 1, 3, 2.
  function automatic logic [1:0] walk_index(input logic [CodeWidth-1:0] code);
    return {code[1], code[1] ^ code[0]};
  endfunction

  task automatic decode_sample(input logic a, input logic b, output bit emit, output bit dir);
    logic [CodeWidth-1:0] code;
    logic [1:0]           delta;
    code = {a ^ inv_a_q, b ^ inv_b_q};
    emit = 1'b0;
    dir  = 1'b0;
    if ((mode_q == MODE_HALF || mode_q == MODE_QUARTER) && !primed_q) begin
      last_code = code;
      primed_q  = 1'b1;
      return;
    end
    case (mode_q)
      MODE_HALF: begin
        if (code == CODE_LL || code == CODE_HH) begin
          if (code != last_code) begin
            last_code = code;
            emit      = 1'b1;
          end
        end else begin
          turn_dir_q = last_code[0] ^ code[0];
        end
      end
      MODE_QUARTER: begin
        // One place forward along the walk is a +1 step, one place back a -1 step.
        delta = walk_index(code) - walk_index(last_code);
        if (delta == 2'd1 || delta == 2'd3) begin
          turn_dir_q = (delta == 2'd1);
          emit       = 1'b1;
        end
        last_code = code;
      end
      default: begin
        // In full mode the stored code is only an armed flag.
        if (code == CODE_LL) begin
          if (last_code != CODE_LL) begin
            last_code = CODE_LL;
            emit      = 1'b1;
          end
        end else if (code == CODE_HH) begin
          last_code = CODE_LH;
        end else if (last_code != CODE_LL) begin
          turn_dir_q = code[1];
        end
      end
    endcase
    dir = turn_dir_q;
  endtask

  task automatic cfg_write(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_STEP_MODE: begin
        mode_q    = data[ModeWidth-1:0];
        last_code = CODE_LL;
        primed_q  = 1'b0;
      end
      REG_INVERT_A: inv_a_q = data[0];
      REG_INVERT_B: inv_b_q = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_sample(input logic a, input logic b, input logic typed,
                             input logic t_emit, input logic t_dir);
    bit emit;
    bit dir;
    while ($urandom_range(99) < sender_idle_pct) begin
      pin_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pin_ch.valid <= 1'b1;
    pin_ch.pin_a <= a;
    pin_ch.pin_b <= b;
    do @(posedge clk_i); while (!pin_ch.ready);
    decode_sample(a, b, emit, dir);
    if (typed) begin
      emit = t_emit;
      dir  = t_dir;
    end
    if (emit) pending_steps.push_back(dir);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every expected step has come out.
  task automatic wait_for_steps();
    pin_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_steps.size() != 0);
  endtask

  task automatic settle_idle();
    wait_for_steps();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    step_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_step
    bit want;
    if (rst_ni && step_ch.valid && step_ch.ready) begin
      steps_seen++;
      if (pending_steps.size() == 0) begin
        flag_mismatch($sformatf("unexpected step, direction %b", step_ch.step_direction));
      end else begin
        want = pending_steps.pop_front();
        if (step_ch.step_direction !== want) begin
          flag_mismatch($sformatf("step direction %b, expected %b",
                                  step_ch.step_direction, want));
        end
      end
    end
  end

  initial begin : stimulus
    logic [1:0]           walk_pos;
    bit                   walk_fwd;
    logic [CodeWidth-1:0] code;
    int                   pick;
    int                   phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_STEP_MODE;
    cfg_wdata_i   = '0;
    pin_ch.valid  = 1'b0;
    pin_ch.pin_a  = 1'b0;
    pin_ch.pin_b  = 1'b0;
    step_ch.ready = 1'b0;
    walk_pos      = 2'd0;
    walk_fwd      = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_idle();
        cfg_write(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].a, directed_rows[i].b, directed_rows[i].typed,
                    directed_rows[i].t_emit, directed_rows[i].t_dir);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle_idle();
      phase           = seg / 2;
      sender_idle_pct = sender_pct_by_phase[phase];
      recv_stall_pct  = stall_pct_by_phase[phase];
      cfg_write(REG_INVERT_A, CfgDataWidth'($urandom_range(3)));
      cfg_write(REG_INVERT_B, CfgDataWidth'($urandom_range(3)));
      if (seg == 5) cfg_write(REG_UNUSED, CfgDataWidth'($urandom_range(3)));
      cfg_write(REG_STEP_MODE, seg_modes[seg]);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (n == SEG_ITEMS / 2) wait_for_steps();
        // Mostly a Gray-code walk with the odd reversal, pause or glitch.
        pick = $urandom_range(99);
        if (pick < 75) begin
          walk_pos = walk_fwd ? walk_pos + 2'd1 : walk_pos - 2'd1;
        end else if (pick < 85) begin
          walk_fwd = ~walk_fwd;
          walk_pos = walk_fwd ? walk_pos + 2'd1 : walk_pos - 2'd1;
        end
        code = {walk_pos[1], walk_pos[1] ^ walk_pos[0]};
        if (pick >= 92) code = CodeWidth'($urandom_range(3));
        send_sample(code[1], code[0], 1'b0, 1'b0, 1'b0);
      end
    end

    settle_idle();
    $display("Run covered %0d pin samples and %0d step items in full, half, quarter and",
             samples_sent, steps_seen);
    $display("unused-mode decoding, with pin inversion, mode rewrites and idling phases.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d steps still expected.", pending_steps.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
design/qrd_pkg.sv
design/qrd_if.sv
design/qrd_decode.sv
design/quadrature_rotary_decoder_core.sv
tb/tb_quadrature_rotary_decoder_core.sv
